[sv/ubxff_pkg.sv]
package ubxff_pkg;

    localparam int unsigned MAX_PAYLOAD = 128;

    localparam logic [7:0] SYNC_A = 8'hB5;
    localparam logic [7:0] SYNC_B = 8'h62;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_CODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_CODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_LENGTH = 2'd2;

    localparam logic [7:0] RST_CLASS_CODE      = 8'd1;
    localparam logic [7:0] RST_MESSAGE_CODE    = 8'd7;
    localparam logic [7:0] RST_EXPECTED_LENGTH = 8'd92;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CK_A    = 4'd7,
        PH_CK_B    = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_ACCEPT  = 2'd1,
        EV_CK_FAIL = 2'd2
    } t_event;

endpackage

[sv/ubx_frame_filter_checker_top.sv]
// UBX frame filter and checker. Takes one receiver byte per transaction and
// returns one result transaction per byte: payload bytes of a frame that
// matches the configured class, id and length are marked with their offset,
// and the CK_B byte reports whether the Fletcher-8 checksum passed or failed.
// A byte flagged end_of_read is processed and then returns the parser to
// hunting. One byte is taken per clock unless the output stalls: the parser
// state and both checksum sums update in a single cycle, the result is
// registered, and that register frees the input side whenever it is empty or
// being taken. The user must write configuration through the plain write port
// only while idle (unchecked); indexes beyond the three registers are ignored.
module ubx_frame_filter_checker_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_read,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_payload_valid,
    output logic [6:0] o_payload_offset,
    output logic [7:0] o_payload_byte,
    output logic [1:0] o_frame_event,
    input  logic       i_cfg_wr_en,
    input  logic [ubxff_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import ubxff_pkg::*;

    logic [7:0] r_class_code;
    logic [7:0] r_message_code;
    logic [7:0] r_expected_length;

    t_phase     r_phase, n_phase;
    logic [7:0] r_sum_first, n_sum_first;
    logic [7:0] r_sum_second, n_sum_second;
    logic [7:0] r_len_low, n_len_low;
    logic [7:0] r_count, n_count;
    logic [7:0] r_ck_first, n_ck_first;

    logic       r_out_valid;
    logic       r_pv, n_pv;
    logic [6:0] r_poff, n_poff;
    logic [7:0] r_pbyte, n_pbyte;
    t_event     r_event, n_event;

    logic       in_acc;
    logic [7:0] add_first;
    logic [7:0] add_second;
    logic [7:0] count_inc;
    t_phase     rehunt;
    logic       len_ok;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign add_first  = r_sum_first + i_data_byte;
    assign add_second = r_sum_second + add_first;
    assign count_inc  = r_count + 8'd1;
    assign rehunt     = (i_data_byte == SYNC_A) ? PH_SYNC2 : PH_HUNT;
    assign len_ok     = (i_data_byte == 8'd0) && (r_len_low == r_expected_length) &&
                        ({24'd0, r_expected_length} <= 32'(MAX_PAYLOAD));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_code      <= RST_CLASS_CODE;
            r_message_code    <= RST_MESSAGE_CODE;
            r_expected_length <= RST_EXPECTED_LENGTH;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_CLASS_CODE:      r_class_code      <= i_cfg_data;
                CFG_MESSAGE_CODE:    r_message_code    <= i_cfg_data;
                CFG_EXPECTED_LENGTH: r_expected_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase      = rehunt;
        n_sum_first  = r_sum_first;
        n_sum_second = r_sum_second;
        n_len_low    = r_len_low;
        n_count      = r_count;
        n_ck_first   = r_ck_first;
        n_pv         = 1'b0;
        n_poff       = 7'd0;
        n_pbyte      = 8'd0;
        n_event      = EV_NONE;
        unique case (r_phase)
            PH_SYNC2: begin
                if (i_data_byte == SYNC_B) begin
                    n_sum_first  = 8'd0;
                    n_sum_second = 8'd0;
                    n_phase      = PH_CLASS;
                end
            end
            PH_CLASS: begin
                if (i_data_byte == r_class_code) begin
                    n_sum_first  = add_first;
                    n_sum_second = add_second;
                    n_phase      = PH_ID;
                end
            end
            PH_ID: begin
                if (i_data_byte == r_message_code) begin
                    n_sum_first  = add_first;
                    n_sum_second = add_second;
                    n_phase      = PH_LEN_LO;
                end
            end
            PH_LEN_LO: begin
                n_len_low    = i_data_byte;
                n_sum_first  = add_first;
                n_sum_second = add_second;
                n_phase      = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                if (len_ok) begin
                    n_sum_first  = add_first;
                    n_sum_second = add_second;
                    n_count      = 8'd0;
                    n_phase      = (r_expected_length == 8'd0) ? PH_CK_A : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_pv         = 1'b1;
                n_poff       = r_count[6:0];
                n_pbyte      = i_data_byte;
                n_sum_first  = add_first;
                n_sum_second = add_second;
                n_count      = count_inc;
                n_phase      = (count_inc >= r_expected_length) ? PH_CK_A : PH_PAYLOAD;
            end
            PH_CK_A: begin
                n_ck_first = i_data_byte;
                n_phase    = PH_CK_B;
            end
            PH_CK_B: begin
                if ((r_ck_first == r_sum_first) && (i_data_byte == r_sum_second)) begin
                    n_event = EV_ACCEPT;
                    n_phase = PH_HUNT;
                end else begin
                    n_event = EV_CK_FAIL;
                end
            end
            default: ;
        endcase
        if (i_end_of_read) begin
            n_phase = PH_HUNT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_sum_first  <= 8'd0;
            r_sum_second <= 8'd0;
            r_len_low    <= 8'd0;
            r_count      <= 8'd0;
            r_ck_first   <= 8'd0;
        end else if (in_acc) begin
            r_phase      <= n_phase;
            r_sum_first  <= n_sum_first;
            r_sum_second <= n_sum_second;
            r_len_low    <= n_len_low;
            r_count      <= n_count;
            r_ck_first   <= n_ck_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pv    <= n_pv;
            r_poff  <= n_poff;
            r_pbyte <= n_pbyte;
            r_event <= n_event;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_payload_valid  = r_pv;
    assign o_payload_offset = r_poff;
    assign o_payload_byte   = r_pbyte;
    assign o_frame_event    = r_event;

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty result register");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("accepted byte produced no result");

    a_payload_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_payload_valid) |-> (o_frame_event == EV_NONE))
        else $error("payload byte carries a frame event");

    a_eor_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_end_of_read) |=> (r_phase == PH_HUNT))
        else $error("end of read did not return to hunting");

endmodule

[dv/ubxff_checker.sv]
`timescale 1ns / 100ps

module ubxff_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_end_of_read,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic                            i_payload_valid,
    input  logic [6:0]                      i_payload_offset,
    input  logic [7:0]                      i_payload_byte,
    input  logic [1:0]                      i_frame_event,
    input  logic                            i_cfg_wr_en,
    input  logic [ubxff_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                      i_cfg_data,
    output int                              o_fail_count,
    output int                              o_outstanding
);
    import ubxff_pkg::*;

    typedef struct packed {
        logic       pv;
        logic [6:0] off;
        logic [7:0] pbyte;
        t_event     ev;
    } t_byte_result;

    logic [7:0]   class_sel;
    logic [7:0]   msg_sel;
    logic [7:0]   len_sel;
    t_phase       phase;
    logic [7:0]   fl_a;
    logic [7:0]   fl_b;
    logic [7:0]   len_lo_seen;
    logic [7:0]   pay_count;
    logic [7:0]   ck_a_seen;
    t_byte_result byte_results_q[$];

    function automatic t_phase resync(input logic [7:0] b);
        return (b == SYNC_A) ? PH_SYNC2 : PH_HUNT;
    endfunction

    function automatic void fletcher_add(input logic [7:0] b);
        fl_a = fl_a + b;
        fl_b = fl_b + fl_a;
    endfunction

    function automatic t_byte_result parse_byte(input logic [7:0] b, input logic eor);
        t_byte_result r;
        t_phase       nxt;
        r = '0;
        case (phase)
            PH_SYNC2: begin
                if (b == SYNC_B) begin
                    fl_a = 8'h00;
                    fl_b = 8'h00;
                    nxt = PH_CLASS;
                end else begin
                    nxt = resync(b);
                end
            end
            PH_CLASS: begin
                if (b == class_sel) begin
                    fletcher_add(b);
                    nxt = PH_ID;
                end else begin
                    nxt = resync(b);
                end
            end
            PH_ID: begin
                if (b == msg_sel) begin
                    fletcher_add(b);
                    nxt = PH_LEN_LO;
                end else begin
                    nxt = resync(b);
                end
            end
            PH_LEN_LO: begin
                len_lo_seen = b;
                fletcher_add(b);
                nxt = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                if (b == 8'h00 && len_lo_seen == len_sel && len_sel <= MAX_PAYLOAD) begin
                    fletcher_add(b);
                    pay_count = 8'h00;
                    nxt = (len_sel == 8'h00) ? PH_CK_A : PH_PAYLOAD;
                end else begin
                    nxt = resync(b);
                end
            end
            PH_PAYLOAD: begin
                r.pv = 1'b1;
                r.off = pay_count[6:0];
                r.pbyte = b;
                fletcher_add(b);
                pay_count = pay_count + 8'd1;
                nxt = (pay_count >= len_sel) ? PH_CK_A : PH_PAYLOAD;
            end
            PH_CK_A: begin
                ck_a_seen = b;
                nxt = PH_CK_B;
            end
            PH_CK_B: begin
                if (ck_a_seen == fl_a && b == fl_b) begin
                    r.ev = EV_ACCEPT;
                    nxt = PH_HUNT;
                end else begin
                    r.ev = EV_CK_FAIL;
                    nxt = resync(b);
                end
            end
            default: begin
                nxt = resync(b);
            end
        endcase
        phase = eor ? PH_HUNT : nxt;
        return r;
    endfunction

    function automatic int field_diff(input string name, input logic [7:0] want_v,
                                      input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, actual %0d", name, want_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_byte_result want;
        if (!i_rst_n) begin
            class_sel = RST_CLASS_CODE;
            msg_sel = RST_MESSAGE_CODE;
            len_sel = RST_EXPECTED_LENGTH;
            phase = PH_HUNT;
            fl_a = 8'h00;
            fl_b = 8'h00;
            len_lo_seen = 8'h00;
            pay_count = 8'h00;
            ck_a_seen = 8'h00;
            byte_results_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (byte_results_q.size() == 0) begin
                    $error("result transaction with no byte pending, frame_event %0d",
                           i_frame_event);
                    o_fail_count++;
                end else begin
                    want = byte_results_q.pop_front();
                    o_fail_count += field_diff("payload_valid", {7'd0, want.pv},
                                               {7'd0, i_payload_valid});
                    o_fail_count += field_diff("payload_offset", {1'b0, want.off},
                                               {1'b0, i_payload_offset});
                    o_fail_count += field_diff("payload_byte", want.pbyte, i_payload_byte);
                    o_fail_count += field_diff("frame_event", {6'd0, want.ev},
                                               {6'd0, i_frame_event});
                end
            end
            if (i_in_valid && !i_in_stall) begin
                byte_results_q.push_back(parse_byte(i_data_byte, i_end_of_read));
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_CLASS_CODE:      class_sel = i_cfg_data;
                    CFG_MESSAGE_CODE:    msg_sel = i_cfg_data;
                    CFG_EXPECTED_LENGTH: len_sel = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_outstanding <= byte_results_q.size();
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import ubxff_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES = 80;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [7:0]           i_data_byte;
    logic                 i_end_of_read;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_payload_valid;
    logic [6:0]           o_payload_offset;
    logic [7:0]           o_payload_byte;
    logic [1:0]           o_frame_event;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]           i_cfg_data;
    int                   fail_count;
    int                   outstanding;
    int                   quiet_cycles;

    logic       steady;
    logic       hold_armed;
    logic       hold_done;
    logic [7:0] cfg_class;
    logic [7:0] cfg_msg;
    logic [7:0] cfg_len;
    logic [8:0] tx_q[$];

    ubx_frame_filter_checker_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_end_of_read    (i_end_of_read),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_payload_valid  (o_payload_valid),
        .o_payload_offset (o_payload_offset),
        .o_payload_byte   (o_payload_byte),
        .o_frame_event    (o_frame_event),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    ubxff_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_end_of_read    (i_end_of_read),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_payload_valid  (o_payload_valid),
        .i_payload_offset (o_payload_offset),
        .i_payload_byte   (o_payload_byte),
        .i_frame_event    (o_frame_event),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        i_out_stall = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_armed && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            i_out_stall <= !steady && ($urandom_range(99) < 25);
        end
    end

    task automatic send_byte(input logic [8:0] item);
        while (!steady && $urandom_range(99) < 25) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        {i_end_of_read, i_data_byte} <= item;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain_tx();
        while (tx_q.size() != 0) send_byte(tx_q.pop_front());
    endtask

    task automatic set_filter(input logic [7:0] cls, input logic [7:0] msg,
                              input logic [7:0] len);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        cfg_class = cls;
        cfg_msg = msg;
        cfg_len = len;
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_CLASS_CODE;
        i_cfg_data <= cls;
        @(posedge i_clk);
        i_cfg_index <= CFG_MESSAGE_CODE;
        i_cfg_data <= msg;
        @(posedge i_clk);
        i_cfg_index <= CFG_UNUSED;
        i_cfg_data <= 8'($urandom_range(255));
        @(posedge i_clk);
        i_cfg_index <= CFG_EXPECTED_LENGTH;
        i_cfg_data <= len;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(9))
            0, 1, 2: return SYNC_A;
            3:       return SYNC_B;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void queue_frame();
        logic [7:0] fr[$];
        logic [7:0] sum_a;
        logic [7:0] sum_b;
        int         n_pay;
        int         kind;
        int         cut;
        logic       eor_on;
        n_pay = (cfg_len > MAX_PAYLOAD) ? int'($urandom_range(3)) : int'(cfg_len);
        fr = '{SYNC_A, SYNC_B, cfg_class, cfg_msg, cfg_len, 8'h00};
        repeat (n_pay) fr.push_back(8'($urandom_range(255)));
        sum_a = 8'h00;
        sum_b = 8'h00;
        for (int k = 2; k < fr.size(); k++) begin
            sum_a += fr[k];
            sum_b += sum_a;
        end
        fr.push_back(sum_a);
        fr.push_back(sum_b);
        kind = $urandom_range(99);
        cut = fr.size() - 1;
        eor_on = ($urandom_range(9) == 0);
        if (kind < 10) begin
            fr[cut - $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
        end else if (kind < 15) begin
            fr[cut] = SYNC_A;
        end else if (kind < 27) begin
            fr[$urandom_range(5)] = ($urandom_range(1) == 1) ? SYNC_A : 8'($urandom_range(255));
        end else if (kind < 39) begin
            cut = $urandom_range(fr.size() - 1);
            eor_on = 1'b1;
        end
        for (int k = 0; k <= cut; k++) tx_q.push_back({eor_on && (k == cut), fr[k]});
    endfunction

    task automatic run_phase(input logic [7:0] cls, input logic [7:0] msg,
                             input logic [7:0] len, input int n_bytes, input logic squeeze);
        int sent;
        set_filter(cls, msg, len);
        hold_armed = squeeze;
        sent = 0;
        while (sent < n_bytes) begin
            if ($urandom_range(99) < 80) begin
                queue_frame();
            end else begin
                repeat ($urandom_range(1, 6)) tx_q.push_back({($urandom_range(9) == 0),
                                                              noise_byte()});
            end
            sent += tx_q.size();
            drain_tx();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_data_byte = 8'h00;
        i_end_of_read = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_CLASS_CODE;
        i_cfg_data = 8'h00;
        steady = 1'b0;
        hold_armed = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bit 8 flags end of read
        set_filter(8'h01, 8'h07, 8'd0);
        tx_q = '{9'h0FF, 9'h0B5, 9'h062, 9'h001, 9'h007, 9'h000, 9'h000, 9'h0F7, 9'h0B5,
                 9'h062, 9'h001, 9'h007, 9'h000, 9'h000, 9'h008, 9'h119,
                 9'h0B5, 9'h062, 9'h001, 9'h0B5, 9'h062, 9'h001, 9'h007, 9'h000, 9'h001};
        drain_tx();

        run_phase(RST_CLASS_CODE, RST_MESSAGE_CODE, RST_EXPECTED_LENGTH, 250, 1'b0);
        run_phase(8'h00, 8'hFF, 8'd0, 150, 1'b0);
        steady = 1'b1;
        run_phase(8'hFF, 8'h00, 8'd5, 200, 1'b0);
        steady = 1'b0;
        run_phase(SYNC_A, SYNC_B, 8'd3, 200, 1'b1);
        repeat (3) begin
            run_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(12)), 150, 1'b0);
        end
        run_phase(8'h06, 8'h01, 8'd128, 300, 1'b0);
        run_phase(8'h01, 8'h07, 8'd129, 60, 1'b0);
        run_phase(8'h01, 8'h07, 8'd255, 60, 1'b0);

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[ubx_frame_filter_checker_top.f]
sv/ubxff_pkg.sv
sv/ubx_frame_filter_checker_top.sv
dv/ubxff_checker.sv
dv/testbench.sv
